/* src/egsa_pkg.sv */
package egsa_pkg;

  // fixed field widths of the channels
  localparam int SAMPLE_W  = 16;
  localparam int ENCODER_W = 16;
  localparam int BYTE_W    = 8;

  // defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int ENCODER_BITS_DEF = 16;

  // configuration registers
  localparam int LIMIT_W    = 10;
  localparam int STEPS_W    = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_BLOCK = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd400;
  localparam logic [STEPS_W-1:0] STEPS_RST = 8'd200;

  // frame bytes
  localparam logic [BYTE_W-1:0] FRAME_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] FRAME_END = 8'hFF;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    BYTE_MEAN_LO = 3'd0,
    BYTE_MEAN_HI = 3'd1,
    BYTE_ENC_LO  = 3'd2,
    BYTE_ENC_HI  = 3'd3,
    BYTE_CR      = 3'd4,
    BYTE_END     = 3'd5
  } frame_byte_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SEND = 3'b100
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* src/egsa_if.sv */
interface egsa_in_if;
  logic                           valid;
  logic                           ready;
  logic [egsa_pkg::SAMPLE_W-1:0]  sample;
  logic [egsa_pkg::ENCODER_W-1:0] encoder_count;

  modport source (output valid, sample, encoder_count, input ready);
  modport sink   (input valid, sample, encoder_count, output ready);
endinterface

interface egsa_out_if;
  logic                        valid;
  logic                        ready;
  logic [egsa_pkg::BYTE_W-1:0] out_byte;
  logic                        last_of_step;
  logic                        last_of_block;

  modport source (output valid, out_byte, last_of_step, last_of_block, input ready);
  modport sink   (input valid, out_byte, last_of_step, last_of_block, output ready);
endinterface

/* src/egsa_front.sv */
module egsa_front #(
  parameter int SAMPLE_BITS  = egsa_pkg::SAMPLE_BITS_DEF,
  parameter int ENCODER_BITS = egsa_pkg::ENCODER_BITS_DEF,
  parameter int SUM_W        = SAMPLE_BITS + egsa_pkg::LIMIT_W,
  parameter int REC_W        = SUM_W + egsa_pkg::LIMIT_W + ENCODER_BITS + 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [egsa_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic [egsa_pkg::ENCODER_W-1:0]     in_encoder_count,
  input  logic [egsa_pkg::LIMIT_W-1:0]       sample_limit,
  input  logic [egsa_pkg::STEPS_W-1:0]       steps_per_block,
  input  egsa_pkg::queue_stat_t              q_stat,
  output logic                               push,
  output logic [REC_W-1:0]                   push_data
);

  logic                          open_r;
  logic [ENCODER_BITS-1:0]       ref_r;
  logic [SUM_W-1:0]              sum_r;
  logic [egsa_pkg::LIMIT_W-1:0]  cnt_r;
  logic [egsa_pkg::STEPS_W-1:0]  step_idx_r;

  logic [SAMPLE_BITS-1:0]        smp;
  logic [ENCODER_BITS-1:0]       enc;
  logic [ENCODER_BITS-1:0]       ref_val;
  logic [SUM_W-1:0]              sum_base;
  logic [egsa_pkg::LIMIT_W-1:0]  cnt_base;
  logic [SUM_W-1:0]              sum_nxt;
  logic [egsa_pkg::LIMIT_W-1:0]  cnt_nxt;
  logic                          close;
  logic [egsa_pkg::STEPS_W:0]    step_plus;
  logic                          block_end;
  logic                          in_fire;

  assign in_ready = !q_stat.full;
  assign in_fire  = in_valid && in_ready;

  assign smp = in_sample[SAMPLE_BITS-1:0];
  assign enc = in_encoder_count[ENCODER_BITS-1:0];

  // a tick with no step open starts a fresh one
  assign ref_val  = open_r ? ref_r : enc;
  assign sum_base = open_r ? sum_r : '0;
  assign cnt_base = open_r ? cnt_r : '0;

  always_comb begin
    sum_nxt = sum_base;
    cnt_nxt = cnt_base;
    if (cnt_base < sample_limit) begin
      sum_nxt = sum_base + SUM_W'(smp);
      cnt_nxt = cnt_base + 1'b1;
    end
  end

  assign close     = (enc != ref_val);
  assign step_plus = {1'b0, step_idx_r} + 1'b1;
  assign block_end = (step_plus >= {1'b0, steps_per_block});

  assign push      = in_fire && close;
  assign push_data = {block_end, enc, cnt_nxt, sum_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      step_idx_r <= '0;
    end else if (in_fire) begin
      if (close) begin
        open_r     <= 1'b0;
        step_idx_r <= block_end ? '0 : step_plus[egsa_pkg::STEPS_W-1:0];
      end else begin
        open_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !close) begin
      ref_r <= ref_val;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* src/egsa_queue.sv */
module egsa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = egsa_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output egsa_pkg::queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/egsa_back.sv */
module egsa_back #(
  parameter int SAMPLE_BITS  = egsa_pkg::SAMPLE_BITS_DEF,
  parameter int ENCODER_BITS = egsa_pkg::ENCODER_BITS_DEF,
  parameter int SUM_W        = SAMPLE_BITS + egsa_pkg::LIMIT_W,
  parameter int REC_W        = SUM_W + egsa_pkg::LIMIT_W + ENCODER_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  egsa_pkg::queue_stat_t         q_stat,
  input  logic [REC_W-1:0]              pop_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [egsa_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last_of_step,
  output logic                          out_last_of_block
);

  localparam int LW     = egsa_pkg::LIMIT_W;
  localparam int ITER_W = $clog2(SAMPLE_BITS + 1);

  egsa_pkg::back_state_t state_r;
  egsa_pkg::frame_byte_t pos_r;
  logic [LW-1:0]                    rem_r;
  logic [LW-1:0]                    div_r;
  logic [SAMPLE_BITS-1:0]           quo_r;
  logic [ITER_W-1:0]                iter_r;
  logic [egsa_pkg::ENCODER_W-1:0]   enc_r;
  logic                             end_r;
  logic                             out_valid_r;
  logic [egsa_pkg::BYTE_W-1:0]      byte_r;
  logic                             los_r;
  logic                             lob_r;

  logic [SUM_W-1:0]         rec_sum;
  logic [LW-1:0]            rec_cnt;
  logic [ENCODER_BITS-1:0]  rec_enc;
  logic                     rec_end;
  logic [LW:0]              trial;
  logic                     ge;
  logic [LW:0]              diff;
  logic [LW-1:0]            rem_nxt;
  logic [SAMPLE_BITS-1:0]   quo_nxt;
  logic [egsa_pkg::SAMPLE_W-1:0] mean;
  logic                     load_ok;
  logic [egsa_pkg::BYTE_W-1:0] sel_byte;
  egsa_pkg::frame_byte_t    pos_nxt;

  assign rec_sum = pop_data[SUM_W-1:0];
  assign rec_cnt = pop_data[SUM_W +: LW];
  assign rec_enc = pop_data[SUM_W+LW +: ENCODER_BITS];
  assign rec_end = pop_data[REC_W-1];

  assign pop = (state_r == egsa_pkg::ST_IDLE) && !q_stat.empty;

  // restoring division, one quotient bit per cycle
  assign trial   = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign ge      = (trial >= {1'b0, div_r});
  assign diff    = trial - {1'b0, div_r};
  assign rem_nxt = ge ? diff[LW-1:0] : trial[LW-1:0];
  assign quo_nxt = {quo_r[SAMPLE_BITS-2:0], ge};

  assign mean    = egsa_pkg::SAMPLE_W'(quo_r);
  assign load_ok = !out_valid_r || out_ready;

  always_comb begin
    case (pos_r)
      egsa_pkg::BYTE_MEAN_LO: begin
        sel_byte = mean[7:0];
        pos_nxt  = egsa_pkg::BYTE_MEAN_HI;
      end
      egsa_pkg::BYTE_MEAN_HI: begin
        sel_byte = mean[15:8];
        pos_nxt  = egsa_pkg::BYTE_ENC_LO;
      end
      egsa_pkg::BYTE_ENC_LO: begin
        sel_byte = enc_r[7:0];
        pos_nxt  = egsa_pkg::BYTE_ENC_HI;
      end
      egsa_pkg::BYTE_ENC_HI: begin
        sel_byte = enc_r[15:8];
        pos_nxt  = egsa_pkg::BYTE_CR;
      end
      egsa_pkg::BYTE_CR: begin
        sel_byte = egsa_pkg::FRAME_CR;
        pos_nxt  = egsa_pkg::BYTE_END;
      end
      egsa_pkg::BYTE_END: begin
        sel_byte = egsa_pkg::FRAME_END;
        pos_nxt  = egsa_pkg::BYTE_MEAN_LO;
      end
      default: begin
        sel_byte = egsa_pkg::FRAME_END;
        pos_nxt  = egsa_pkg::BYTE_MEAN_LO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egsa_pkg::ST_IDLE;
      pos_r       <= egsa_pkg::BYTE_MEAN_LO;
      out_valid_r <= 1'b0;
    end else begin
      // a new byte fills the slot, else a taken byte frees it
      if (state_r == egsa_pkg::ST_SEND && load_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        egsa_pkg::ST_IDLE: begin
          if (pop) begin
            pos_r <= egsa_pkg::BYTE_MEAN_LO;
            // an empty sum averages to zero
            state_r <= (rec_cnt == '0) ? egsa_pkg::ST_SEND : egsa_pkg::ST_DIV;
          end
        end
        egsa_pkg::ST_DIV: begin
          if (iter_r == '0) begin
            state_r <= egsa_pkg::ST_SEND;
          end
        end
        egsa_pkg::ST_SEND: begin
          if (load_ok) begin
            pos_r <= pos_nxt;
            if (pos_r == egsa_pkg::BYTE_END) begin
              state_r <= egsa_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= egsa_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem_r  <= rec_sum[SUM_W-1:SAMPLE_BITS];
      quo_r  <= (rec_cnt == '0) ? '0 : rec_sum[SAMPLE_BITS-1:0];
      div_r  <= rec_cnt;
      iter_r <= ITER_W'(SAMPLE_BITS - 1);
      enc_r  <= egsa_pkg::ENCODER_W'(rec_enc);
      end_r  <= rec_end;
    end else if (state_r == egsa_pkg::ST_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      iter_r <= iter_r - 1'b1;
    end
    if (state_r == egsa_pkg::ST_SEND && load_ok) begin
      byte_r <= sel_byte;
      los_r  <= (pos_r == egsa_pkg::BYTE_END);
      lob_r  <= (pos_r == egsa_pkg::BYTE_END) && end_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = byte_r;
  assign out_last_of_step  = los_r;
  assign out_last_of_block = lob_r;

endmodule

/* src/encoder_gated_sample_averager.sv */
// Averages ADC samples over each encoder step and sends one six-byte frame per
// step: mean low, mean high, encoder low, encoder high, 0x0D, 0xFF. Ticks are
// taken one per cycle while the queue is not full; a tick whose encoder count
// differs from the one latched at the start of the step closes it and writes a
// record into a four-entry queue. The back end turns each record into a frame
// by bit-serial division followed by the six byte loads, and takes the next
// record only once the last byte of the frame is loaded. The input stalls on
// any tick while the queue is full, i.e. when steps close faster than the back
// end drains them (or the output is held off). No start-up pass after reset;
// config writes are to be made only while the block is idle; the block itself
// does not enforce this.
module encoder_gated_sample_averager #(
  parameter int SAMPLE_BITS  = egsa_pkg::SAMPLE_BITS_DEF,
  parameter int ENCODER_BITS = egsa_pkg::ENCODER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [egsa_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [egsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  egsa_in_if.sink                            in_ch,
  egsa_out_if.source                         out_ch
);

  localparam int SUM_W = SAMPLE_BITS + egsa_pkg::LIMIT_W;
  localparam int REC_W = SUM_W + egsa_pkg::LIMIT_W + ENCODER_BITS + 1;

  logic [egsa_pkg::LIMIT_W-1:0] limit_r;
  logic [egsa_pkg::STEPS_W-1:0] steps_r;

  egsa_pkg::queue_stat_t q_stat;
  logic             push;
  logic [REC_W-1:0] push_data;
  logic             pop;
  logic [REC_W-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= egsa_pkg::LIMIT_RST;
      steps_r <= egsa_pkg::STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        egsa_pkg::CFG_SAMPLE_LIMIT:    limit_r <= cfg_data[egsa_pkg::LIMIT_W-1:0];
        egsa_pkg::CFG_STEPS_PER_BLOCK: steps_r <= cfg_data[egsa_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  egsa_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENCODER_BITS(ENCODER_BITS),
    .SUM_W       (SUM_W),
    .REC_W       (REC_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_sample       (in_ch.sample),
    .in_encoder_count(in_ch.encoder_count),
    .sample_limit    (limit_r),
    .steps_per_block (steps_r),
    .q_stat          (q_stat),
    .push            (push),
    .push_data       (push_data)
  );

  egsa_queue #(
    .WIDTH(REC_W),
    .DEPTH(egsa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .stat     (q_stat)
  );

  egsa_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENCODER_BITS(ENCODER_BITS),
    .SUM_W       (SUM_W),
    .REC_W       (REC_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop_data         (pop_data),
    .pop              (pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_byte         (out_ch.out_byte),
    .out_last_of_step (out_ch.last_of_step),
    .out_last_of_block(out_ch.last_of_block)
  );

endmodule

/* src/egsa_checker.sv */
module egsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [egsa_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last_of_step,
  input logic                        out_last_of_block
);

  // a waiting request keeps its byte and flags
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_last_of_step) && $stable(out_last_of_block))
    else $error("output request dropped or changed while stalled");

  a_block_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_block |-> out_last_of_step)
    else $error("block end flagged off a frame end");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_step |-> out_byte == egsa_pkg::FRAME_END)
    else $error("frame end flag on a byte other than the end marker");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output request right after reset");

endmodule

bind encoder_gated_sample_averager egsa_checker u_egsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_byte         (out_ch.out_byte),
  .out_last_of_step (out_ch.last_of_step),
  .out_last_of_block(out_ch.last_of_block)
);
